[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on a clock, one of them disabled by an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge, off while reset is asserted
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// property checked on every edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/itb_pkg.sv]
// ----------------------------------------------------------------------------
// itb_pkg
// shared constants and control types of the base-b digit converter
// ----------------------------------------------------------------------------
package itb_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int VAL_W       = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CODE_W      = 7;
    localparam int POS_W       = 5;
    localparam int CNT_W       = $clog2(VAL_W);

    localparam logic [VAL_W-1:0] VALUE_MASK = (VALUE_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
        VAL_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [CODE_W-1:0]  CODE_OFFSET = 7'd48;
    localparam logic [POS_W-1:0]   POS_LAST    = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(VAL_W - 1);

    typedef struct packed {
        logic load;
        logic next;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic last;
        logic out_free;
    } ctrl_stat_t;

endpackage

[src/itb_div.sv]
// ----------------------------------------------------------------------------
// itb_div
// restoring divider, one quotient bit per cycle, narrow divisor
// ----------------------------------------------------------------------------
module itb_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [itb_pkg::VAL_W-1:0]   dividend,
    input  logic [itb_pkg::RADIX_W-1:0] divisor,
    output logic                        busy,
    output logic [itb_pkg::VAL_W-1:0]   quotient,
    output logic [itb_pkg::RADIX_W-1:0] remainder
);

    logic                        busy_reg, busy_next;
    logic [itb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [itb_pkg::VAL_W-1:0]   quo_reg, quo_next;
    logic [itb_pkg::RADIX_W-1:0] rem_reg, rem_next;
    logic [itb_pkg::RADIX_W:0]   trial;
    logic [itb_pkg::RADIX_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[itb_pkg::VAL_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[itb_pkg::RADIX_W-1:0];
                quo_next = {quo_reg[itb_pkg::VAL_W-2:0], 1'b1};
            end else begin
                rem_next = trial[itb_pkg::RADIX_W-1:0];
                quo_next = {quo_reg[itb_pkg::VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == itb_pkg::CNT_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[src/itb_dpath.sv]
// ----------------------------------------------------------------------------
// itb_dpath
// radix register, digit loop registers, divider and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itb_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [itb_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic [itb_pkg::VAL_W-1:0]   s_value,
    input  itb_pkg::ctrl_cmd_t          cmd,
    output itb_pkg::ctrl_stat_t         stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [itb_pkg::DIGIT_W-1:0] m_digit,
    output logic [itb_pkg::CODE_W-1:0]  m_digit_code,
    output logic [itb_pkg::POS_W-1:0]   m_position,
    output logic [itb_pkg::VAL_W-1:0]   m_place_value,
    output logic                        m_last_digit
);

    logic [itb_pkg::RADIX_W-1:0] radix_reg;
    logic [itb_pkg::RADIX_W-1:0] eff_radix;
    logic [itb_pkg::VAL_W-1:0]   power_reg, power_next;
    logic [itb_pkg::POS_W-1:0]   idx_reg, idx_next;
    logic                        div_start;
    logic [itb_pkg::VAL_W-1:0]   div_dividend;
    logic                        div_busy;
    logic [itb_pkg::VAL_W-1:0]   div_quo;
    logic [itb_pkg::RADIX_W-1:0] div_rem;
    logic [itb_pkg::VAL_W+itb_pkg::RADIX_W-1:0] power_prod;
    logic [itb_pkg::VAL_W+itb_pkg::RADIX_W-1:0] place_prod;
    logic                        last;
    logic                        out_valid_reg, out_valid_next;
    logic [itb_pkg::DIGIT_W-1:0] digit_reg;
    logic [itb_pkg::CODE_W-1:0]  code_reg;
    logic [itb_pkg::POS_W-1:0]   pos_reg;
    logic [itb_pkg::VAL_W-1:0]   place_reg;
    logic                        last_reg;

    always_comb begin
        if (radix_reg < itb_pkg::RADIX_MIN) begin
            eff_radix = itb_pkg::RADIX_MIN;
        end else if (radix_reg > itb_pkg::RADIX_MAX) begin
            eff_radix = itb_pkg::RADIX_MAX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    assign div_start    = cmd.load | cmd.next;
    assign div_dividend = cmd.load ? (s_value & itb_pkg::VALUE_MASK) : div_quo;

    itb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_radix),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign power_prod = power_reg * eff_radix;
    assign place_prod = power_reg * div_rem;
    assign last       = (div_quo == '0) || (idx_reg == itb_pkg::POS_LAST);

    always_comb begin
        power_next = power_reg;
        idx_next   = idx_reg;
        if (cmd.load) begin
            power_next = itb_pkg::VAL_W'(1);
            idx_next   = '0;
        end else if (cmd.next) begin
            power_next = power_prod[itb_pkg::VAL_W-1:0];
            idx_next   = idx_reg + 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= itb_pkg::RADIX_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
        power_reg <= power_next;
        idx_reg   <= idx_next;
        if (cmd.emit) begin
            digit_reg <= div_rem;
            code_reg  <= {1'b0, div_rem} + itb_pkg::CODE_OFFSET;
            pos_reg   <= idx_reg;
            place_reg <= place_prod[itb_pkg::VAL_W-1:0];
            last_reg  <= last;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.last     = last;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_digit       = digit_reg;
    assign m_digit_code  = code_reg;
    assign m_position    = pos_reg;
    assign m_place_value = place_reg;
    assign m_last_digit  = last_reg;

    // digit taken only from a finished division
    `ASSERT_CLK_RST(a_emit_div_done, aclk, aresetn, cmd.emit |-> !div_busy, "emit while dividing")
    // pending result never overwritten
    `ASSERT_CLK_RST(a_emit_no_overwrite, aclk, aresetn, cmd.emit |-> (!out_valid_reg || m_ready), "result overwritten")
    // partial remainder stays below the divisor
    `ASSERT_CLK_RST(a_rem_range, aclk, aresetn, div_busy |-> (div_rem < eff_radix), "remainder out of range")

endmodule

[src/itb_ctrl.sv]
// ----------------------------------------------------------------------------
// itb_ctrl
// sequencer of the digit loop: load, divide, emit one digit, repeat
// ----------------------------------------------------------------------------
module itb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itb_pkg::ctrl_stat_t stat,
    output itb_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/integer_to_base_b_digits_core.sv]
// ----------------------------------------------------------------------------
// integer_to_base_b_digits_core
// splits an unsigned integer into digits of the configured base, lsd first
//
//   channel  dir  ports                                         role
//   s_       in   s_valid s_ready s_value                       value to convert
//   m_       out  m_valid m_ready m_digit m_digit_code          one digit per transfer
//                 m_position m_place_value m_last_digit
//   cfg_     in   cfg_wr_en cfg_wr_data                         radix, reset 10
//
// each digit passes the bit-serial divider, then ST_DIV sees it done and ST_EMIT emits it
// s_ready is high once the last digit of the previous value sits in the result register
// m_ready low while a result is pending holds the sequencer before the next emit, the divider result waits
// reset is synchronous, active low, and needs no clearing pass
// ----------------------------------------------------------------------------
module integer_to_base_b_digits_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [itb_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [itb_pkg::VAL_W-1:0]   s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [itb_pkg::DIGIT_W-1:0] m_digit,
    output logic [itb_pkg::CODE_W-1:0]  m_digit_code,
    output logic [itb_pkg::POS_W-1:0]   m_position,
    output logic [itb_pkg::VAL_W-1:0]   m_place_value,
    output logic                        m_last_digit
);

    itb_pkg::ctrl_cmd_t  cmd;
    itb_pkg::ctrl_stat_t stat;

    itb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    itb_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_value       (s_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit       (m_digit),
        .m_digit_code  (m_digit_code),
        .m_position    (m_position),
        .m_place_value (m_place_value),
        .m_last_digit  (m_last_digit)
    );

endmodule
